// File: hdl/mrcs_pkg.sv
// Shared types and constants of the Modbus RTU coil slave.
// Used by every module of the block; depends on nothing.
package mrcs_pkg;

  localparam int unsigned FRAME_DEPTH = 256;
  localparam int unsigned LEN_W       = $clog2(FRAME_DEPTH + 1);
  localparam int unsigned HEAD_N      = 6;
  localparam int unsigned CFG_IDX_W   = 1;
  localparam int unsigned CFG_DATA_W  = 16;
  localparam int unsigned MSG_N_W     = 3;

  localparam logic [15:0] CRC_POLY = 16'hA001;
  localparam logic [15:0] CRC_INIT = 16'hFFFF;

  localparam logic [7:0] FN_READ       = 8'h03;
  localparam logic [7:0] FN_WRITE_COIL = 8'h05;
  localparam logic [7:0] FN_EXC_FLAG   = 8'h80;
  localparam logic [7:0] READ_COUNT    = 8'h02;
  localparam logic [7:0] EXC_ILLEGAL   = 8'h01;
  localparam logic [7:0] COIL_ON_HI    = 8'hFF;
  localparam logic [7:0] BYTE_ZERO     = 8'h00;

  localparam logic OP_BYTE = 1'b0;
  localparam logic OP_TICK = 1'b1;

  localparam logic [CFG_IDX_W-1:0] REG_SLAVE_ADDR = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SILENCE    = 1'd1;

  typedef struct packed {
    logic        operation;
    logic [7:0]  rx_data;
    logic [15:0] register_value;
  } in_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       tx_last;
    logic       coil0_on;
    logic       coil1_on;
  } out_t;

  typedef logic [HEAD_N-1:0][7:0] msg_t;

  typedef struct packed {
    logic       clr;
    logic       start;
    logic [7:0] data;
  } crc_req_t;

  typedef struct packed {
    logic        busy;
    logic [15:0] crc;
  } crc_rsp_t;

endpackage

// File: hdl/mrcs_crc.sv
// Bit-serial CRC-16 engine, reflected polynomial, one shift per cycle.
// Depends on mrcs_pkg for the request and response structs.
module mrcs_crc (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  mrcs_pkg::crc_req_t req_i,
  output mrcs_pkg::crc_rsp_t rsp_o
);
  import mrcs_pkg::*;

  logic [15:0] crc_q, crc_d;
  logic [3:0]  cnt_q, cnt_d;

  always_comb begin
    crc_d = crc_q;
    cnt_d = cnt_q;
    if (req_i.clr) begin
      crc_d = CRC_INIT;
      cnt_d = 4'd0;
    end else if (req_i.start) begin
      crc_d = crc_q ^ {8'h00, req_i.data};
      cnt_d = 4'd8;
    end else if (cnt_q != 4'd0) begin
      crc_d = crc_q[0] ? ((crc_q >> 1) ^ CRC_POLY) : (crc_q >> 1);
      cnt_d = cnt_q - 4'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      crc_q <= CRC_INIT;
      cnt_q <= 4'd0;
    end else begin
      crc_q <= crc_d;
      cnt_q <= cnt_d;
    end
  end

  assign rsp_o.busy = (cnt_q != 4'd0);
  assign rsp_o.crc  = crc_q;

endmodule

// File: hdl/mrcs_tx.sv
// Response sequencer: shifts the message out a byte at a time, feeds each
// byte to the shared CRC engine and appends the CRC. Depends on mrcs_pkg.
module mrcs_tx (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        load_i,
  input  mrcs_pkg::msg_t              msg_i,
  input  logic [mrcs_pkg::MSG_N_W-1:0] len_i,
  input  logic [1:0]                  coil_i,
  output logic                        busy_o,
  output mrcs_pkg::crc_req_t          crc_req_o,
  input  mrcs_pkg::crc_rsp_t          crc_rsp_i,
  output logic                        out_valid_o,
  input  logic                        out_stall_i,
  output mrcs_pkg::out_t              out_data_o
);
  import mrcs_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MSG  = 2'd1;
  localparam logic [1:0] S_CRCH = 2'd2;

  logic [1:0]         state_q, state_d;
  msg_t               msg_q, msg_d;
  logic [MSG_N_W-1:0] rem_q, rem_d;
  logic               valid_q, valid_d;
  out_t               data_q, data_d;
  logic               free;

  assign free = !valid_q || !out_stall_i;

  always_comb begin
    state_d   = state_q;
    msg_d     = msg_q;
    rem_d     = rem_q;
    valid_d   = valid_q && out_stall_i;
    data_d    = data_q;
    crc_req_o = '0;
    unique case (state_q)
      S_IDLE: begin
        if (load_i) begin
          msg_d   = msg_i;
          rem_d   = len_i;
          state_d = S_MSG;
        end
      end
      S_MSG: begin
        if (free && !crc_rsp_i.busy) begin
          valid_d = 1'b1;
          if (rem_q != '0) begin
            data_d          = '{tx_byte: msg_q[0], tx_last: 1'b0,
                                coil0_on: coil_i[0], coil1_on: coil_i[1]};
            crc_req_o.start = 1'b1;
            crc_req_o.data  = msg_q[0];
            msg_d           = {8'h00, msg_q[HEAD_N-1:1]};
            rem_d           = rem_q - MSG_N_W'(1);
          end else begin
            data_d  = '{tx_byte: crc_rsp_i.crc[7:0], tx_last: 1'b0,
                        coil0_on: coil_i[0], coil1_on: coil_i[1]};
            state_d = S_CRCH;
          end
        end
      end
      S_CRCH: begin
        if (free) begin
          valid_d       = 1'b1;
          data_d        = '{tx_byte: crc_rsp_i.crc[15:8], tx_last: 1'b1,
                            coil0_on: coil_i[0], coil1_on: coil_i[1]};
          crc_req_o.clr = 1'b1;
          state_d       = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      rem_q   <= '0;
      valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      rem_q   <= rem_d;
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    msg_q  <= msg_d;
    data_q <= data_d;
  end

  assign busy_o      = (state_q != S_IDLE);
  assign out_valid_o = valid_q;
  assign out_data_o  = data_q;

endmodule

// File: hdl/modbus_rtu_coil_slave.sv
// Top level of the Modbus RTU coil slave: frame capture, silence timer,
// frame checks and coil state. Depends on mrcs_pkg, mrcs_crc and mrcs_tx.
//
// The input channel carries one word per received byte or timer tick;
// the output channel carries one word per response byte, with tx_last on
// the final byte and the coil states after the frame was handled.
// Configuration registers are written through cfg_we_i, cfg_idx_i and
// cfg_data_i by the user while the block is idle, which it does not enforce.
// A received byte is accepted when the input is not stalled; from the third
// byte of a frame up to the 256th, the input then stalls while the
// bit-serial CRC engine folds the byte that left the two-byte tail. A
// tick that ends a valid frame starts the response, unless the frame is a
// coil write that fails its field checks: each message byte goes through
// the same CRC engine once it has finished the previous byte, and the two
// CRC words follow, low byte first, for a 5 to 8 word reply. The input
// stays stalled until the last response word is in the output register.
// A stall from the receiver holds the output register and delays the
// rest of the reply. Reset loads the default address 1 and a silence
// limit of 4 ticks, stops the timer, empties the frame and turns both
// coils off.
module modbus_rtu_coil_slave (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             cfg_we_i,
  input  logic [mrcs_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  logic [mrcs_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  logic                             in_valid_i,
  output logic                             in_stall_o,
  input  mrcs_pkg::in_t                    in_data_i,
  output logic                             out_valid_o,
  input  logic                             out_stall_i,
  output mrcs_pkg::out_t                   out_data_o
);
  import mrcs_pkg::*;

  logic [7:0]       addr_q;
  logic [15:0]      lim_q;
  logic [7:0]       head_q [HEAD_N];
  logic [7:0]       tail_q [2];
  logic [LEN_W-1:0] len_q;
  logic             ovf_q;
  logic [15:0]      sil_q;
  logic             tmr_q;
  logic [1:0]       coil_q, coil_d;

  crc_req_t crc_req, tx_crc_req;
  crc_rsp_t crc_rsp;
  logic     tx_busy;

  logic        accept, take_byte, take_tick, frame_end, rx_start;
  logic [15:0] sil_inc;
  logic        frame_ok, wr_ok, coil_on, tx_load;
  msg_t        msg;
  logic [MSG_N_W-1:0] msg_len;

  assign in_stall_o = crc_rsp.busy || tx_busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign take_byte  = accept && (in_data_i.operation == OP_BYTE);
  assign take_tick  = accept && (in_data_i.operation == OP_TICK) && tmr_q;
  assign sil_inc    = (sil_q == 16'hFFFF) ? sil_q : sil_q + 16'd1;
  assign frame_end  = take_tick && (sil_inc >= lim_q);
  assign rx_start   = take_byte && (len_q < LEN_W'(FRAME_DEPTH)) && (len_q >= LEN_W'(2));

  assign frame_ok = !ovf_q && (len_q >= LEN_W'(4)) &&
                    ({tail_q[1], tail_q[0]} == crc_rsp.crc) && (head_q[0] == addr_q);
  assign wr_ok    = (len_q >= LEN_W'(8)) && (head_q[2] == BYTE_ZERO) &&
                    (head_q[3] <= 8'd1) && (head_q[5] == BYTE_ZERO) &&
                    ((head_q[4] == COIL_ON_HI) || (head_q[4] == BYTE_ZERO));
  assign coil_on  = (head_q[4] == COIL_ON_HI);

  always_comb begin
    msg     = '0;
    msg_len = '0;
    tx_load = 1'b0;
    coil_d  = coil_q;
    msg[0]  = addr_q;
    if (frame_end && frame_ok) begin
      if (head_q[1] == FN_READ) begin
        msg[1]  = FN_READ;
        msg[2]  = READ_COUNT;
        msg[3]  = in_data_i.register_value[15:8];
        msg[4]  = in_data_i.register_value[7:0];
        msg_len = MSG_N_W'(5);
        tx_load = 1'b1;
      end else if (head_q[1] == FN_WRITE_COIL) begin
        if (wr_ok) begin
          coil_d[head_q[3][0]] = coil_on;
          msg[1]  = FN_WRITE_COIL;
          msg[2]  = BYTE_ZERO;
          msg[3]  = head_q[3];
          msg[4]  = head_q[4];
          msg[5]  = BYTE_ZERO;
          msg_len = MSG_N_W'(6);
          tx_load = 1'b1;
        end
      end else begin
        msg[1]  = head_q[1] | FN_EXC_FLAG;
        msg[2]  = EXC_ILLEGAL;
        msg_len = MSG_N_W'(3);
        tx_load = 1'b1;
      end
    end
  end

  always_comb begin
    crc_req.clr   = frame_end || tx_crc_req.clr;
    crc_req.start = rx_start || tx_crc_req.start;
    crc_req.data  = tx_crc_req.start ? tx_crc_req.data : tail_q[0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q <= 8'd1;
      lim_q  <= 16'd4;
      len_q  <= '0;
      ovf_q  <= 1'b0;
      sil_q  <= '0;
      tmr_q  <= 1'b0;
      coil_q <= '0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_idx_i == REG_SLAVE_ADDR) begin
          addr_q <= cfg_data_i[7:0];
        end else if (cfg_idx_i == REG_SILENCE) begin
          lim_q <= cfg_data_i;
        end
      end
      coil_q <= coil_d;
      if (take_byte) begin
        if (len_q >= LEN_W'(FRAME_DEPTH)) begin
          ovf_q <= 1'b1;
        end else begin
          len_q <= len_q + LEN_W'(1);
        end
        sil_q <= '0;
        tmr_q <= 1'b1;
      end else if (frame_end) begin
        len_q <= '0;
        ovf_q <= 1'b0;
        sil_q <= '0;
        tmr_q <= 1'b0;
      end else if (take_tick) begin
        sil_q <= sil_inc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (take_byte && (len_q < LEN_W'(FRAME_DEPTH))) begin
      if (len_q < LEN_W'(HEAD_N)) begin
        head_q[len_q[2:0]] <= in_data_i.rx_data;
      end
      tail_q[0] <= tail_q[1];
      tail_q[1] <= in_data_i.rx_data;
    end
  end

  mrcs_crc u_crc (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (crc_req),
    .rsp_o  (crc_rsp)
  );

  mrcs_tx u_tx (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .load_i      (tx_load),
    .msg_i       (msg),
    .len_i       (msg_len),
    .coil_i      (coil_d),
    .busy_o      (tx_busy),
    .crc_req_o   (tx_crc_req),
    .crc_rsp_i   (crc_rsp),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

  a_start_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    crc_req.start |-> !crc_rsp.busy)
    else $error("CRC engine started while busy");

  a_end_resets: assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_end |=> (!tmr_q && (len_q == '0) && !ovf_q && (crc_rsp.crc == CRC_INIT)))
    else $error("frame state not cleared after frame end");

  a_no_overlap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tx_busy |-> !rx_start)
    else $error("received byte folded while response is in progress");

endmodule

// File: verif/tb_modbus_rtu_coil_slave.sv
// Testbench for the Modbus RTU coil slave: random and directed frames and ticks,
// checked word by word against a predictor of the slave kept in this file.
// Depends on mrcs_pkg and modbus_rtu_coil_slave.
`timescale 1ns / 100ps

module tb_modbus_rtu_coil_slave;
  import mrcs_pkg::*;

  localparam int QUIET_LIMIT   = 3000;
  localparam int SETTLE_CYCLES = 200;
  localparam int IDLE_PCT      = 6;

  typedef logic [7:0] octets_t [$];

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            cfg_we_i    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_idx_i  = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i = '0;
  logic            in_valid    = 1'b0;
  logic            in_stall_o;
  in_t             in_data     = '0;
  logic            out_valid_o;
  logic            out_stall_i = 1'b0;
  out_t            out_data_o;

  modbus_rtu_coil_slave dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .in_valid_i (in_valid),
    .in_stall_o (in_stall_o),
    .in_data_i  (in_data),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .out_data_o (out_data_o)
  );

  always #5 clk_i = ~clk_i;

  in_t  rx_word_q [$];
  out_t tx_expect_q [$];
  int   gap_pct   = IDLE_PCT;
  int   stall_pct = IDLE_PCT;
  int   errors    = 0;
  int   queued    = 0;
  int   accepted  = 0;
  int   checked   = 0;
  int   answered  = 0;
  int   quiet     = 0;
  bit   stuck     = 1'b0;

  // Shadow of the slave: configuration and frame state.
  logic [7:0]  cfg_addr    = 8'd1;
  logic [15:0] cfg_silence = 16'd4;
  logic [7:0]  frm_head [HEAD_N];
  logic [7:0]  frm_tail [2];
  logic [15:0] frm_crc     = CRC_INIT;
  int          frm_len     = 0;
  bit          frm_ovf     = 1'b0;
  logic [15:0] quiet_cnt   = '0;
  bit          timer_on    = 1'b0;
  logic [1:0]  coil_bits   = '0;

  function automatic logic [15:0] crc16_update(input logic [15:0] c, input logic [7:0] b);
    c = c ^ {8'h00, b};
    for (int k = 0; k < 8; k++) begin
      if (c[0]) begin
        c = (c >> 1) ^ CRC_POLY;
      end else begin
        c = c >> 1;
      end
    end
    return c;
  endfunction

  task automatic report_error(input string msg);
    $display("ERROR @%0t: %s", $time, msg);
    errors++;
  endtask

  task automatic answer_frame(input logic [15:0] value);
    logic [7:0]  msg [8];
    logic [15:0] c;
    logic        on;
    int          n;
    out_t        r;
    if (frm_ovf || frm_len < 4) return;
    if ({frm_tail[1], frm_tail[0]} != frm_crc) return;
    if (frm_head[0] != cfg_addr) return;
    msg[0] = cfg_addr;
    if (frm_head[1] == FN_READ) begin
      msg[1] = FN_READ;
      msg[2] = READ_COUNT;
      msg[3] = value[15:8];
      msg[4] = value[7:0];
      n = 5;
    end else if (frm_head[1] == FN_WRITE_COIL) begin
      if (frm_len < 8 || frm_head[2] != BYTE_ZERO || frm_head[3] > 1 ||
          frm_head[5] != BYTE_ZERO) return;
      if (frm_head[4] == COIL_ON_HI) begin
        on = 1'b1;
      end else if (frm_head[4] == BYTE_ZERO) begin
        on = 1'b0;
      end else begin
        return;
      end
      coil_bits[frm_head[3][0]] = on;
      msg[1] = FN_WRITE_COIL;
      msg[2] = BYTE_ZERO;
      msg[3] = frm_head[3];
      msg[4] = on ? COIL_ON_HI : BYTE_ZERO;
      msg[5] = BYTE_ZERO;
      n = 6;
    end else begin
      msg[1] = frm_head[1] | FN_EXC_FLAG;
      msg[2] = EXC_ILLEGAL;
      n = 3;
    end
    c = CRC_INIT;
    for (int i = 0; i < n; i++) c = crc16_update(c, msg[i]);
    msg[n]     = c[7:0];
    msg[n + 1] = c[15:8];
    for (int i = 0; i < n + 2; i++) begin
      r.tx_byte  = msg[i];
      r.tx_last  = (i == n + 1);
      r.coil0_on = coil_bits[0];
      r.coil1_on = coil_bits[1];
      tx_expect_q.push_back(r);
    end
    answered++;
  endtask

  task automatic slave_predict(input in_t w);
    if (w.operation == OP_BYTE) begin
      if (frm_len >= FRAME_DEPTH) begin
        frm_ovf = 1'b1;
      end else begin
        if (frm_len < HEAD_N) frm_head[frm_len] = w.rx_data;
        if (frm_len >= 2) frm_crc = crc16_update(frm_crc, frm_tail[0]);
        frm_tail[0] = frm_tail[1];
        frm_tail[1] = w.rx_data;
        frm_len++;
      end
      quiet_cnt = '0;
      timer_on  = 1'b1;
    end else if (timer_on) begin
      if (quiet_cnt != 16'hFFFF) quiet_cnt++;
      if (quiet_cnt >= cfg_silence) begin
        answer_frame(w.register_value);
        frm_len   = 0;
        frm_ovf   = 1'b0;
        frm_crc   = CRC_INIT;
        quiet_cnt = '0;
        timer_on  = 1'b0;
      end
    end
  endtask

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid && !in_stall_o) begin
        slave_predict(in_data);
        accepted++;
      end
      if (!in_valid || !in_stall_o) begin
        if (rx_word_q.size() != 0 && $urandom_range(99) >= gap_pct) begin
          in_valid <= 1'b1;
          in_data  <= rx_word_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    out_t want;
    if (rst_ni) begin
      out_stall_i <= ($urandom_range(99) < stall_pct);
      if (out_valid_o && !out_stall_i) begin
        if (tx_expect_q.size() == 0) begin
          report_error($sformatf("unexpected response word %h", out_data_o));
        end else begin
          want = tx_expect_q.pop_front();
          checked++;
          if (out_data_o.tx_byte !== want.tx_byte)
            report_error($sformatf("tx_byte %h, expected %h", out_data_o.tx_byte, want.tx_byte));
          if (out_data_o.tx_last !== want.tx_last)
            report_error($sformatf("tx_last %b, expected %b", out_data_o.tx_last, want.tx_last));
          if (out_data_o.coil0_on !== want.coil0_on)
            report_error($sformatf("coil0_on %b, expected %b", out_data_o.coil0_on,
                                   want.coil0_on));
          if (out_data_o.coil1_on !== want.coil1_on)
            report_error($sformatf("coil1_on %b, expected %b", out_data_o.coil1_on,
                                   want.coil1_on));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((in_valid && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
        quiet <= 0;
      end else begin
        quiet <= quiet + 1;
      end
      if (quiet >= QUIET_LIMIT) stuck <= 1'b1;
    end
  end

  initial begin
    wait (stuck);
    $display("FAIL");
    $finish;
  end

  function automatic int frame_ticks();
    return (cfg_silence == 0) ? 1 : int'(cfg_silence);
  endfunction

  function automatic int inner_gap();
    return (frame_ticks() - 1 < 3) ? frame_ticks() - 1 : 3;
  endfunction

  task automatic add_byte(input logic [7:0] b);
    in_t w;
    w.operation      = OP_BYTE;
    w.rx_data        = b;
    w.register_value = 16'($urandom_range(16'hFFFF));
    rx_word_q.push_back(w);
    queued++;
  endtask

  task automatic add_tick(input logic [15:0] value);
    in_t w;
    w.operation      = OP_TICK;
    w.rx_data        = 8'($urandom_range(255));
    w.register_value = value;
    rx_word_q.push_back(w);
    queued++;
  endtask

  // Sends the bytes, with short gaps of ticks below the silence limit, then
  // the CRC unless raw, then enough ticks to close the frame.
  task automatic send_frame(input octets_t body, input bit bad_crc, input bit raw,
                            input logic [15:0] value);
    logic [15:0] c;
    c = CRC_INIT;
    foreach (body[i]) c = crc16_update(c, body[i]);
    if (bad_crc) c = c ^ (16'h1 << $urandom_range(15));
    if (!raw) begin
      body.push_back(c[7:0]);
      body.push_back(c[15:8]);
    end
    foreach (body[i]) begin
      add_byte(body[i]);
      if (i != body.size() - 1 && inner_gap() > 0 && $urandom_range(3) == 0)
        repeat ($urandom_range(1, inner_gap())) add_tick(16'($urandom_range(16'hFFFF)));
    end
    repeat (frame_ticks() - 1) add_tick(16'($urandom_range(16'hFFFF)));
    add_tick(value);
    if ($urandom_range(7) == 0)
      repeat ($urandom_range(1, 2)) add_tick(16'($urandom_range(16'hFFFF)));
  endtask

  function automatic octets_t coil_body();
    octets_t b;
    b.push_back(cfg_addr);
    b.push_back(FN_WRITE_COIL);
    b.push_back(BYTE_ZERO);
    b.push_back(8'($urandom_range(1)));
    b.push_back($urandom_range(1) ? COIL_ON_HI : BYTE_ZERO);
    b.push_back(BYTE_ZERO);
    return b;
  endfunction

  task automatic add_random_frame();
    octets_t     body;
    int          kind;
    int          k;
    bit          bad;
    bit          raw;
    logic [7:0]  fn;
    logic [7:0]  other;
    kind = $urandom_range(99);
    bad  = 1'b0;
    raw  = 1'b0;
    body.push_back(cfg_addr);
    if (kind < 30) begin
      body.push_back(FN_READ);
      if ($urandom_range(3) != 0) repeat (4) body.push_back(8'($urandom_range(255)));
    end else if (kind < 60) begin
      body = coil_body();
    end else if (kind < 68) begin
      body = coil_body();
      k = $urandom_range(2, 5);
      case (k)
        3:       body[k] = 8'($urandom_range(2, 255));
        4:       body[k] = 8'($urandom_range(1, 254));
        default: body[k] = 8'($urandom_range(1, 255));
      endcase
    end else if (kind < 73) begin
      body = coil_body();
      repeat ($urandom_range(1, 4)) void'(body.pop_back());
    end else if (kind < 81) begin
      do fn = 8'($urandom_range(255)); while (fn == FN_READ || fn == FN_WRITE_COIL);
      body.push_back(fn);
      repeat ($urandom_range(0, 4)) body.push_back(8'($urandom_range(255)));
    end else if (kind < 87) begin
      if ($urandom_range(1)) begin
        body = coil_body();
      end else begin
        body.push_back(FN_READ);
        repeat (4) body.push_back(8'($urandom_range(255)));
      end
      bad = 1'b1;
    end else if (kind < 93) begin
      do other = 8'($urandom_range(255)); while (other == cfg_addr);
      body[0] = other;
      body.push_back($urandom_range(1) ? FN_READ : FN_WRITE_COIL);
      repeat (4) body.push_back(8'($urandom_range(255)));
    end else begin
      raw = 1'b1;
      body.delete();
      repeat ((kind < 97) ? $urandom_range(1, 3) : $urandom_range(1, 12))
        body.push_back(8'($urandom_range(255)));
    end
    send_frame(body, bad, raw, 16'($urandom_range(16'hFFFF)));
  endtask

  task automatic random_frames(input int count);
    int start;
    start = queued;
    while (queued - start < count) add_random_frame();
  endtask

  task automatic wait_idle();
    while (rx_word_q.size() != 0 || in_valid) @(posedge clk_i);
    while (tx_expect_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] value);
    @(posedge clk_i);
    cfg_we_i   <= 1'b1;
    cfg_idx_i  <= idx;
    cfg_data_i <= value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_SLAVE_ADDR) begin
      cfg_addr = value[7:0];
    end else begin
      cfg_silence = value;
    end
  endtask

  task automatic set_config(input logic [7:0] addr, input logic [15:0] silence);
    wait_idle();
    write_reg(REG_SLAVE_ADDR, {8'h00, addr});
    write_reg(REG_SILENCE, silence);
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Reset defaults: a tick with no frame, a full read, an exception.
    add_tick(16'h0000);
    send_frame('{8'h01, FN_READ, 8'h00, 8'h00, 8'h00, 8'h01}, 1'b0, 1'b0, 16'hFFFF);
    send_frame('{8'h01, 8'h00}, 1'b0, 1'b0, 16'h0000);

    set_config(8'($urandom_range(1, 247)), 16'd1);
    random_frames(80);

    set_config(8'd247, 16'd3);
    gap_pct   = 0;
    stall_pct = 0;
    random_frames(70);
    wait_idle();
    gap_pct   = IDLE_PCT;
    stall_pct = IDLE_PCT;

    set_config(8'($urandom_range(1, 247)), 16'd0);
    random_frames(50);

    set_config(8'($urandom_range(1, 247)), 16'd2);
    random_frames(70);

    wait_idle();
    $display("Checked %0d response words in %0d replies from %0d accepted input words.",
             checked, answered, accepted);
    $display("Addresses 1, 247 and random; silence limits 0 to 4; short, bad and foreign frames.");
    if (errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// File: files.f
hdl/mrcs_pkg.sv
hdl/mrcs_crc.sv
hdl/mrcs_tx.sv
hdl/modbus_rtu_coil_slave.sv
verif/tb_modbus_rtu_coil_slave.sv
